/* src/rss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants for the rectangle subtraction splitter.
// ----------------------------------------------------------------------------
package rss_pkg;

   // Number of pieces one subtraction can produce.
   localparam int NUM_PIECES = 4;

   // Piece slots, in the order in which the pieces leave the block.
   localparam int PIECE_LEFT   = 0;
   localparam int PIECE_TOP    = 1;
   localparam int PIECE_RIGHT  = 2;
   localparam int PIECE_BOTTOM = 3;

   // Which of the edge tests (left, top, right, bottom) cut a piece off the subject.
   typedef struct packed {
      logic bottom;
      logic right;
      logic top;
      logic left;
   } rss_hits_type;

endpackage

/* src/rss_clip.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rss_clip
// Combinational clip-and-split: runs the left, top, right and bottom edge
// tests on a subject rectangle and returns the four candidate pieces.
// ----------------------------------------------------------------------------
module rss_clip
   import rss_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic signed [COORD_BITS-1:0]                  subject_top,
   input  logic signed [COORD_BITS-1:0]                  subject_left,
   input  logic signed [COORD_BITS-1:0]                  subject_bottom,
   input  logic signed [COORD_BITS-1:0]                  subject_right,
   input  logic signed [COORD_BITS-1:0]                  cut_top,
   input  logic signed [COORD_BITS-1:0]                  cut_left,
   input  logic signed [COORD_BITS-1:0]                  cut_bottom,
   input  logic signed [COORD_BITS-1:0]                  cut_right,
   output rss_hits_type                                  hits,
   output logic        [NUM_PIECES-1:0][COORD_BITS-1:0]  piece_top,
   output logic        [NUM_PIECES-1:0][COORD_BITS-1:0]  piece_left,
   output logic        [NUM_PIECES-1:0][COORD_BITS-1:0]  piece_bottom,
   output logic        [NUM_PIECES-1:0][COORD_BITS-1:0]  piece_right
);

   localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

   logic signed [COORD_BITS-1:0] left_cut;
   logic signed [COORD_BITS-1:0] top_cut;
   logic signed [COORD_BITS-1:0] right_cut;

   // Each test sees the subject as shrunk by the tests before it.
   always_comb begin
      hits.left   = (cut_left > subject_left) && (cut_left <= subject_right);
      left_cut    = hits.left ? cut_left : subject_left;
      hits.top    = (cut_top > subject_top) && (cut_top <= subject_bottom);
      top_cut     = hits.top ? cut_top : subject_top;
      hits.right  = (cut_right >= left_cut) && (cut_right < subject_right);
      right_cut   = hits.right ? cut_right : subject_right;
      hits.bottom = (cut_bottom >= top_cut) && (cut_bottom < subject_bottom);
   end

   always_comb begin
      piece_top[PIECE_LEFT]      = subject_top;
      piece_left[PIECE_LEFT]     = subject_left;
      piece_bottom[PIECE_LEFT]   = subject_bottom;
      piece_right[PIECE_LEFT]    = cut_left - ONE;

      piece_top[PIECE_TOP]       = subject_top;
      piece_left[PIECE_TOP]      = left_cut;
      piece_bottom[PIECE_TOP]    = cut_top - ONE;
      piece_right[PIECE_TOP]     = subject_right;

      piece_top[PIECE_RIGHT]     = top_cut;
      piece_left[PIECE_RIGHT]    = cut_right + ONE;
      piece_bottom[PIECE_RIGHT]  = subject_bottom;
      piece_right[PIECE_RIGHT]   = subject_right;

      piece_top[PIECE_BOTTOM]    = cut_bottom + ONE;
      piece_left[PIECE_BOTTOM]   = left_cut;
      piece_bottom[PIECE_BOTTOM] = subject_bottom;
      piece_right[PIECE_BOTTOM]  = right_cut;
   end

endmodule

/* src/rect_subtract_split_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_subtract_split_top
// Rectangle subtraction: splits a subject rectangle into the up to four
// pieces that a cutting rectangle leaves visible (left, top, right, bottom).
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Payload
//   -------   ---------   ------------------------------------------------
//   req_*     in          subject and cutting rectangle, 8 coordinates
//   rsp_*     out         one piece per transfer, tuser = piece_valid,
//                         tlast = last_piece
//
// An accepted request sits in the hold register; the clip logic evaluates
// it combinationally and one piece is moved into the response register per
// cycle unless it is stalled, so a request with k pieces gives max(k, 1)
// transfers, at most four. The first response is registered after the
// request has passed the hold register. A new request is taken in the same
// cycle in which the last piece of the held one moves to the response
// register, so requests follow each other without gaps. A stalled response
// register holds its content and simply freezes the piece walk. The
// synchronous reset clears only the valid flags and the sent-piece mask.
// ----------------------------------------------------------------------------
module rect_subtract_split_top
   import rss_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_tvalid,
   output logic                        req_tready,
   // From bit 0 up: subject_top, subject_left, subject_bottom, subject_right,
   // cut_top, cut_left, cut_bottom, cut_right.
   input  logic [8*COORD_BITS-1:0]     req_tdata,

   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // From bit 0 up: piece_top, piece_left, piece_bottom, piece_right,
   // then zero fill to a whole byte.
   output logic [((4*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   // Bit 0: piece_valid.
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int RSP_BITS = ((4*COORD_BITS+7)/8)*8;
   localparam int CB       = COORD_BITS;

   // Hold register for the request being split.
   logic                    hold_valid_ff;
   logic [8*CB-1:0]         hold_data_ff;
   logic [NUM_PIECES-1:0]   sent_ff;
   logic [NUM_PIECES-1:0]   sent_in;

   // Response register.
   logic                    rsp_valid_ff;
   logic [4*CB-1:0]         rsp_data_ff;
   logic [4*CB-1:0]         rsp_data_in;
   logic                    rsp_piece_ff;
   logic                    rsp_piece_in;
   logic                    rsp_last_ff;
   logic                    rsp_last_in;

   rss_hits_type                      hits;
   logic [NUM_PIECES-1:0][CB-1:0]     cand_top;
   logic [NUM_PIECES-1:0][CB-1:0]     cand_left;
   logic [NUM_PIECES-1:0][CB-1:0]     cand_bottom;
   logic [NUM_PIECES-1:0][CB-1:0]     cand_right;

   logic [NUM_PIECES-1:0]   remaining;
   logic [NUM_PIECES-1:0]   pick;
   logic                    pick_last;
   logic                    out_load;
   logic                    req_xfer;

   rss_clip #(
      .COORD_BITS (CB)
   ) u_clip (
      .subject_top    (hold_data_ff[0*CB +: CB]),
      .subject_left   (hold_data_ff[1*CB +: CB]),
      .subject_bottom (hold_data_ff[2*CB +: CB]),
      .subject_right  (hold_data_ff[3*CB +: CB]),
      .cut_top        (hold_data_ff[4*CB +: CB]),
      .cut_left       (hold_data_ff[5*CB +: CB]),
      .cut_bottom     (hold_data_ff[6*CB +: CB]),
      .cut_right      (hold_data_ff[7*CB +: CB]),
      .hits           (hits),
      .piece_top      (cand_top),
      .piece_left     (cand_left),
      .piece_bottom   (cand_bottom),
      .piece_right    (cand_right)
   );

   // Pieces still to send, lowest slot first. When only one remains (or
   // none at all, which means that no edge test hit) this transfer
   // closes the request.
   assign remaining = hits & ~sent_ff;
   assign pick      = remaining & (~remaining + NUM_PIECES'(1));
   assign pick_last = (remaining & ~pick) == '0;

   assign out_load   = hold_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !hold_valid_ff || (out_load && pick_last);
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      rsp_data_in  = '0;
      rsp_piece_in = 1'b0;
      rsp_last_in  = pick_last;
      sent_in      = sent_ff | pick;
      for (int i = 0; i < NUM_PIECES; i++) begin
         if (pick[i]) begin
            rsp_data_in  = {cand_right[i], cand_bottom[i], cand_left[i], cand_top[i]};
            rsp_piece_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         sent_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_xfer) begin
            hold_valid_ff <= 1'b1;
            sent_ff       <= '0;
         end else if (out_load && pick_last) begin
            hold_valid_ff <= 1'b0;
            sent_ff       <= '0;
         end else if (out_load) begin
            sent_ff       <= sent_in;
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         hold_data_ff <= req_tdata;
      end
      if (out_load) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_piece_ff <= rsp_piece_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_data_ff);
   assign rsp_tuser  = rsp_piece_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
